// ===== design/g2e_pkg.sv =====
// Shared types, constants and elaboration-time functions for the geodetic to ECEF block.
// Depends on nothing; used by geodetic_to_ecef and its testbench.
`timescale 1ns / 1ps

package g2e_pkg;

  localparam int CORDIC_STAGES = 28;
  localparam int MAX_STAGES    = 40;
  localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  // Angle word: Q40 degrees; rotation vector: Q40.
  localparam int ZW = 50;
  localparam int XW = 44;

  localparam logic signed [63:0] ONE_Q40 = 64'sd1 << 40;
  localparam logic signed [63:0] K_Q40   = 64'sd667681663043;
  localparam logic signed [63:0] E2_Q40  = 64'sd7360548542;
  localparam logic signed [63:0] A_MM    = 64'sd6378137000;
  localparam logic signed [63:0] OUT_LIM = 64'sd6478137000;

  localparam logic signed [31:0] LON_LIM  = 32'sd1509949440;
  localparam logic signed [31:0] LON_HALF = 32'sd754974720;
  localparam logic signed [30:0] LAT_LIM  = 31'sd754974720;
  localparam logic signed [27:0] H_LIM    = 28'sd100000000;

  // Word carried alongside the Newton iteration until the final products.
  typedef struct packed {
    logic signed [63:0] sph;
    logic signed [63:0] cph;
    logic signed [63:0] cla;
    logic signed [63:0] sla;
    logic signed [27:0] h;
  } geo_t;

  // Shift-and-subtract division, evaluated only while building the arctangent table.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent power series in Q58 radians.
  function automatic logic [63:0] atan_series(input logic [63:0] x, input logic [63:0] msq,
                                              input int sh2);
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] k;
    sum = '0;
    t = x;
    k = '0;
    for (int j = 0; j < 64; j++) begin
      if (t != 64'd0) begin
        term = udiv(t, 64'd2 * k + 64'd1);
        if (k[0]) sum = sum - term;
        else sum = sum + term;
        if (msq != 64'd0) t = udiv(t, msq);
        else t = (sh2 >= 64) ? 64'd0 : (t >> sh2);
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q40 degrees, rounded to nearest.
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] q58;
    logic [63:0] quarter;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    q58 = 64'd1 << 58;
    quarter = 64'd4 * atan_series(udiv(q58, 64'd5), 64'd25, 0)
              - atan_series(udiv(q58, 64'd239), 64'd57121, 0);
    if (i == 0) begin
      q = 64'd45 << 40;
    end else begin
      num = atan_series(q58 >> i, 64'd0, 2 * i) * 64'd45;
      q = udiv(num, quarter);
      r = num - q * quarter;
      for (int b = 0; b < 40; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= quarter) begin
          q = q | 64'd1;
          r = r - quarter;
        end
      end
      r = r << 1;
      if (r >= quarter) q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

// ===== design/g2e_mulr.sv =====
// Pipelined signed multiply with round-to-nearest (ties away from zero) and a right shift.
// Four register stages; depends on nothing.
`timescale 1ns / 1ps

module g2e_mulr (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic        [6:0]  sh,
  output logic signed [63:0] p
);

  logic [63:0]  mag_a;
  logic [63:0]  mag_b;
  logic         neg1;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg2;
  logic [127:0] sum;
  logic         neg3;
  logic [127:0] shifted;

  assign shifted = sum >> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= a[63] ? 64'(-a) : 64'(a);
      mag_b <= b[63] ? 64'(-b) : 64'(b);
      neg1  <= a[63] ^ b[63];

      // Four 32 by 32 partial products.
      p00  <= 64'(mag_a[31:0])  * 64'(mag_b[31:0]);
      p01  <= 64'(mag_a[31:0])  * 64'(mag_b[63:32]);
      p10  <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
      p11  <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
      neg2 <= neg1;

      sum  <= 128'(p00) + (128'(p01) << 32) + (128'(p10) << 32) + (128'(p11) << 64)
              + (128'd1 << (sh - 7'd1));
      neg3 <= neg2;

      p <= neg3 ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
    end
  end

endmodule

// ===== design/geodetic_to_ecef.sv =====
// Geodetic (WGS84) to earth-centred earth-fixed conversion, top level.
// Throughput: one word per cycle; the whole pipeline advances on one enable and holds on a stall.
// Reset (rst, synchronous, active high) clears the valid bits only; data registers are not reset.
// Depends on g2e_pkg and g2e_mulr.
`timescale 1ns / 1ps

module geodetic_to_ecef (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // lon_deg[31:0], lat_deg[62:32], height_mm[90:63], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // ecef_x_mm[33:0], ecef_y_mm[67:34], ecef_z_mm[101:68], pad
);

  localparam int NSTG = g2e_pkg::NSTG;
  localparam int ZW   = g2e_pkg::ZW;
  localparam int XW   = g2e_pkg::XW;
  // Valid bits: entry stage, the CORDIC stages, the post-CORDIC stage, the arithmetic
  // stages and the output register.
  localparam int LAT  = NSTG + 51;
  localparam int GD   = 44;

  // The whole pipeline moves whenever the output register is free or being emptied.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[LAT-1];

  // ---------------------------------------------------------------------------
  // Entry stage: saturate the inputs, fold longitude into +-90 degrees and note the
  // special angles whose sine or cosine is forced to zero.
  // ---------------------------------------------------------------------------
  logic signed [31:0] lon_in;
  logic signed [30:0] lat_in;
  logic signed [27:0] h_in;
  logic signed [31:0] lon_c;
  logic signed [30:0] lat_c;
  logic signed [27:0] h_c;
  logic signed [31:0] lon_f;
  logic               flip_c;

  assign lon_in = s_tdata[31:0];
  assign lat_in = s_tdata[62:32];
  assign h_in   = s_tdata[90:63];

  always_comb begin
    lon_c = (lon_in > g2e_pkg::LON_LIM) ? g2e_pkg::LON_LIM :
            (lon_in < -g2e_pkg::LON_LIM) ? -g2e_pkg::LON_LIM : lon_in;
    lat_c = (lat_in > g2e_pkg::LAT_LIM) ? g2e_pkg::LAT_LIM :
            (lat_in < -g2e_pkg::LAT_LIM) ? -g2e_pkg::LAT_LIM : lat_in;
    h_c   = (h_in > g2e_pkg::H_LIM) ? g2e_pkg::H_LIM :
            (h_in < -g2e_pkg::H_LIM) ? -g2e_pkg::H_LIM : h_in;
    flip_c = 1'b0;
    lon_f  = lon_c;
    if (lon_c > g2e_pkg::LON_HALF) begin
      lon_f  = lon_c - g2e_pkg::LON_LIM;
      flip_c = 1'b1;
    end else if (lon_c < -g2e_pkg::LON_HALF) begin
      lon_f  = lon_c + g2e_pkg::LON_LIM;
      flip_c = 1'b1;
    end
  end

  // CORDIC rotation vectors; index 0 is the entry stage, index i+1 the output of step i.
  logic signed [ZW-1:0] zp [NSTG+1];
  logic signed [ZW-1:0] zl [NSTG+1];
  logic signed [XW-1:0] xp [NSTG+1];
  logic signed [XW-1:0] yp [NSTG+1];
  logic signed [XW-1:0] xl [NSTG+1];
  logic signed [XW-1:0] yl [NSTG+1];
  logic signed [27:0]   hc [NSTG+1];
  logic [3:0]           fl [NSTG+1];  // pole, antimeridian, quarter meridian, flip

  assign xp[0] = XW'(g2e_pkg::K_Q40);
  assign yp[0] = '0;
  assign xl[0] = XW'(g2e_pkg::K_Q40);
  assign yl[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      zp[0] <= ZW'(lat_c) <<< 17;
      zl[0] <= ZW'(lon_f) <<< 17;
      hc[0] <= h_c;
      fl[0] <= {lat_c == g2e_pkg::LAT_LIM || lat_c == -g2e_pkg::LAT_LIM,
                lon_c == -g2e_pkg::LON_LIM,
                lon_c == g2e_pkg::LON_HALF || lon_c == -g2e_pkg::LON_HALF,
                flip_c};
    end
  end

  // One micro-rotation per stage for latitude and longitude side by side; the angle
  // is in degrees, so the table holds atan(2^-i) in Q40 degrees.
  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ROM_I = ZW'(g2e_pkg::atan_entry(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[i][ZW-1]) begin
          xp[i+1] <= xp[i] - (yp[i] >>> i);
          yp[i+1] <= yp[i] + (xp[i] >>> i);
          zp[i+1] <= zp[i] - ROM_I;
        end else begin
          xp[i+1] <= xp[i] + (yp[i] >>> i);
          yp[i+1] <= yp[i] - (xp[i] >>> i);
          zp[i+1] <= zp[i] + ROM_I;
        end
        if (!zl[i][ZW-1]) begin
          xl[i+1] <= xl[i] - (yl[i] >>> i);
          yl[i+1] <= yl[i] + (xl[i] >>> i);
          zl[i+1] <= zl[i] - ROM_I;
        end else begin
          xl[i+1] <= xl[i] + (yl[i] >>> i);
          yl[i+1] <= yl[i] - (xl[i] >>> i);
          zl[i+1] <= zl[i] + ROM_I;
        end
        hc[i+1] <= hc[i];
        fl[i+1] <= fl[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Post-CORDIC stage: undo the longitude fold and force the special zeros.
  // ---------------------------------------------------------------------------
  g2e_pkg::geo_t g0;
  g2e_pkg::geo_t gd [GD];

  always_ff @(posedge clk) begin
    if (en) begin
      g0.sph <= 64'(yp[NSTG]);
      g0.cph <= fl[NSTG][3] ? 64'sd0 : 64'(xp[NSTG]);
      if (fl[NSTG][1])      g0.cla <= 64'sd0;
      else if (fl[NSTG][0]) g0.cla <= -64'(xl[NSTG]);
      else                  g0.cla <= 64'(xl[NSTG]);
      if (fl[NSTG][2])      g0.sla <= 64'sd0;
      else if (fl[NSTG][0]) g0.sla <= -64'(yl[NSTG]);
      else                  g0.sla <= 64'(yl[NSTG]);
      g0.h <= hc[NSTG];
      gd[0] <= g0;
      for (int k = 1; k < GD; k++) gd[k] <= gd[k-1];
    end
  end
  // gd is a shift register of post-CORDIC words: gd[0] takes g0 and each gd[k] takes gd[k-1].

  // sin^2(lat) from a multiplier, then 1 - e2 s2 and the Newton seed 1 + e2 s2 / 2 in w9 and y9.
  logic signed [63:0] s2;
  logic signed [63:0] e2s2;
  logic signed [63:0] e2s2h;
  logic signed [63:0] w9;
  logic signed [63:0] y9;

  g2e_mulr u_s2  (.clk, .en, .a(g0.sph), .b(g0.sph), .sh(7'd40), .p(s2));
  g2e_mulr u_w   (.clk, .en, .a(g2e_pkg::E2_Q40), .b(s2), .sh(7'd40), .p(e2s2));
  g2e_mulr u_y0  (.clk, .en, .a(g2e_pkg::E2_Q40), .b(s2), .sh(7'd41), .p(e2s2h));

  logic signed [63:0] wd [17];  // delay line of w; wd[0] takes w9
  logic signed [63:0] yd [9];   // delay line of the seed; yd[0] takes y9

  always_ff @(posedge clk) begin
    if (en) begin
      w9 <= g2e_pkg::ONE_Q40 - e2s2;
      y9 <= g2e_pkg::ONE_Q40 + e2s2h;
      wd[0] <= w9;
      yd[0] <= y9;
      for (int k = 1; k < 17; k++) wd[k] <= wd[k-1];
      for (int k = 1; k < 9; k++)  yd[k] <= yd[k-1];
    end
  end

  // First Newton step for 1/sqrt(w): y1 = y (3 - w y^2) / 2.
  logic signed [63:0] yy1;
  logic signed [63:0] ww1;
  logic signed [63:0] tt1;
  logic signed [63:0] y1;
  g2e_mulr u_yy1 (.clk, .en, .a(y9), .b(y9), .sh(7'd40), .p(yy1));
  g2e_mulr u_ww1 (.clk, .en, .a(wd[3]), .b(yy1), .sh(7'd40), .p(ww1));
  g2e_mulr u_y1  (.clk, .en, .a(yd[8]), .b(tt1), .sh(7'd41), .p(y1));

  // Second Newton step, from y1.
  logic signed [63:0] yy2;
  logic signed [63:0] ww2;
  logic signed [63:0] tt2;
  logic signed [63:0] y2;
  logic signed [63:0] y1d [9];  // delay line of y1
  g2e_mulr u_yy2 (.clk, .en, .a(y1), .b(y1), .sh(7'd40), .p(yy2));
  g2e_mulr u_ww2 (.clk, .en, .a(wd[16]), .b(yy2), .sh(7'd40), .p(ww2));
  g2e_mulr u_y2  (.clk, .en, .a(y1d[8]), .b(tt2), .sh(7'd41), .p(y2));

  always_ff @(posedge clk) begin
    if (en) begin
      tt1 <= 3 * g2e_pkg::ONE_Q40 - ww1;
      tt2 <= 3 * g2e_pkg::ONE_Q40 - ww2;
      y1d[0] <= y1;
      for (int k = 1; k < 9; k++) y1d[k] <= y1d[k-1];
    end
  end

  // Prime-vertical radius N (mm, 16 fraction bits) and e2 N.
  logic signed [63:0] n16;
  logic signed [63:0] e2n;
  logic signed [63:0] n16d [4];  // delay line of N
  g2e_mulr u_n   (.clk, .en, .a(g2e_pkg::A_MM), .b(y2), .sh(7'd24), .p(n16));
  g2e_mulr u_m   (.clk, .en, .a(g2e_pkg::E2_Q40), .b(n16), .sh(7'd40), .p(e2n));

  // N + h in rn, (1 - e2) N + h in rz.
  logic signed [63:0] rn;
  logic signed [63:0] rz;
  always_ff @(posedge clk) begin
    if (en) begin
      n16d[0] <= n16;
      for (int k = 1; k < 4; k++) n16d[k] <= n16d[k-1];
      rn <= n16 + (64'(gd[38].h) <<< 16);
      rz <= n16d[3] - e2n + (64'(gd[42].h) <<< 16);
    end
  end

  // Horizontal radius (N + h) cos(lat) in p24; then the three coordinates.
  logic signed [63:0] p24;
  logic signed [63:0] vx;
  logic signed [63:0] vy;
  logic signed [63:0] vz;
  g2e_mulr u_p   (.clk, .en, .a(rn), .b(gd[39].cph), .sh(7'd32), .p(p24));
  g2e_mulr u_vx  (.clk, .en, .a(p24), .b(gd[43].cla), .sh(7'd64), .p(vx));
  g2e_mulr u_vy  (.clk, .en, .a(p24), .b(gd[43].sla), .sh(7'd64), .p(vy));
  g2e_mulr u_vz  (.clk, .en, .a(rz), .b(gd[43].sph), .sh(7'd56), .p(vz));

  // Output register: saturate each coordinate and pack the word.
  function automatic logic [33:0] sat34(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > g2e_pkg::OUT_LIM) ? g2e_pkg::OUT_LIM :
        (v < -g2e_pkg::OUT_LIM) ? -g2e_pkg::OUT_LIM : v;
    return c[33:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {2'b00, sat34(vz), sat34(vy), sat34(vx)};
    end
  end

endmodule

// ===== tb/geodetic_to_ecef_tb.sv =====
// Self-checking testbench for geodetic_to_ecef: drives geodetic words, predicts the ECEF words.
// It carries its own fixed-point predictor with a CORDIC and Newton stage, and checks every word.
// Depends on g2e_pkg and the geodetic_to_ecef RTL.
`timescale 1ns / 1ps

module geodetic_to_ecef_tb;

  localparam longint LON_MAX = 64'sd1509949440;
  localparam longint LAT_MAX = 64'sd754974720;
  localparam longint HGT_MAX = 64'sd100000000;
  localparam longint ECEF_MAX = 64'sd6478137000;
  localparam longint UNIT = 64'sd1 << 40;
  localparam longint ECC2 = 64'sd7360548542;
  localparam longint SEMI_MAJOR = 64'sd6378137000;
  localparam longint GAIN = 64'sd667681663043;
  localparam int RANDOM_WORDS = 1200;
  localparam logic signed [31:0] LON_HALF = g2e_pkg::LON_HALF;
  localparam logic signed [30:0] LAT_LIM = g2e_pkg::LAT_LIM;
  localparam logic signed [27:0] H_LIM = g2e_pkg::H_LIM;

  typedef struct {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic on_axis;      // pole row: x and y must both be zero
  } ecef_t;

  typedef struct {
    logic [31:0] lon;
    logic [30:0] lat;
    logic [27:0] hgt;
    logic on_axis;
  } geo_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [95:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [103:0] m_tdata;

  longint atan_deg [40];
  ecef_t ecef_due [$];
  int mismatches;
  int words_in;
  int words_out;
  bit rx_idle;
  bit tx_idle;
  bit hold_request;

  geodetic_to_ecef dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Arctangent power series in Q58 radians.
  function automatic longint unsigned arctan_q58(longint unsigned x, longint unsigned msq,
                                                 int sh2);
    longint unsigned acc;
    longint unsigned t;
    longint unsigned k;
    acc = 0;
    t = x;
    k = 0;
    while (t != 0) begin
      if (k[0]) acc = acc - t / (2 * k + 1);
      else acc = acc + t / (2 * k + 1);
      if (msq != 0) t = t / msq;
      else t = (sh2 >= 64) ? 0 : t >> sh2;
      k++;
    end
    return acc;
  endfunction

  function automatic void fill_atan_table();
    longint unsigned q58;
    longint unsigned quarter;
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    q58 = 64'd1 << 58;
    quarter = 4 * arctan_q58(q58 / 5, 25, 0) - arctan_q58(q58 / 239, 57121, 0);
    atan_deg[0] = 45 * UNIT;
    for (int i = 1; i < 40; i++) begin
      num = arctan_q58(q58 >> i, 0, 2 * i) * 45;
      q = num / quarter;
      r = num % quarter;
      for (int b = 0; b < 40; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= quarter) begin
          q = q | 1;
          r = r - quarter;
        end
      end
      r = r << 1;
      if (r >= quarter) q = q + 1;
      atan_deg[i] = longint'(q);
    end
  endfunction

  // round(a*b / 2^sh), ties away from zero, full 128 bit product, saturating
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7fff_ffff_ffff_ffff) p = 128'h7fff_ffff_ffff_ffff;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint limit(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // Rotation-mode CORDIC in Q40 degrees; |angle| <= 90 deg.
  function automatic void rotate(longint angle, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    x = GAIN;
    y = 0;
    z = angle;
    for (int i = 0; i < g2e_pkg::NSTG; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_deg[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_deg[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  function automatic ecef_t ecef_of(logic [31:0] lon_w, logic [30:0] lat_w, logic [27:0] hgt_w);
    ecef_t e;
    longint lon, lat, hgt, ang, cla, sla, cph, sph, s2, w, yi, n16, m16, h16;
    longint p24;
    logic flip;
    lon = limit(longint'($signed(lon_w)), LON_MAX);
    lat = limit(longint'($signed(lat_w)), LAT_MAX);
    hgt = limit(longint'($signed(hgt_w)), HGT_MAX);
    rotate(lat * 131072, cph, sph);
    if (lat == LAT_MAX || lat == -LAT_MAX) cph = 0;
    // Longitudes past a quarter turn are folded by half a turn, signs flipped afterwards.
    ang = lon * 131072;
    flip = 1'b0;
    if (ang > 90 * UNIT) begin
      ang = ang - 180 * UNIT;
      flip = 1'b1;
    end else if (ang < -90 * UNIT) begin
      ang = ang + 180 * UNIT;
      flip = 1'b1;
    end
    rotate(ang, cla, sla);
    if (flip) begin
      cla = -cla;
      sla = -sla;
    end
    if (lon == -LON_MAX) sla = 0;
    if (lon == LON_MAX / 2 || lon == -(LON_MAX / 2)) cla = 0;
    // Inverse square root of 1 - e2 sin^2 by two Newton steps.
    s2 = scaled_product(sph, sph, 40);
    w = UNIT - scaled_product(ECC2, s2, 40);
    yi = UNIT + scaled_product(ECC2, s2, 41);
    for (int k = 0; k < 2; k++)
      yi = scaled_product(yi, 3 * UNIT - scaled_product(w, scaled_product(yi, yi, 40), 40), 41);
    n16 = scaled_product(SEMI_MAJOR, yi, 24);
    m16 = n16 - scaled_product(ECC2, n16, 40);
    h16 = hgt * 65536;
    p24 = scaled_product(n16 + h16, cph, 32);
    e.x = 34'(limit(scaled_product(p24, cla, 64), ECEF_MAX));
    e.y = 34'(limit(scaled_product(p24, sla, 64), ECEF_MAX));
    e.z = 34'(limit(scaled_product(m16 + h16, sph, 56), ECEF_MAX));
    e.on_axis = 1'b0;
    return e;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH word %0d %s: got %0d, expected %0d", words_out, what, got, want);
  endtask

  // Sends one geodetic word, idling at random beforehand if tx_idle, and records its prediction.
  task automatic send_point(logic [31:0] lon, logic [30:0] lat, logic [27:0] hgt, logic on_axis);
    ecef_t e;
    if (tx_idle)
      while ($urandom_range(99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, hgt, lat, lon};
    do @(posedge clk); while (!s_tready);
    e = ecef_of(lon, lat, hgt);
    e.on_axis = on_axis;
    ecef_due.push_back(e);
    words_in++;
  endtask

  // Receiver: checks each accepted word against the oldest prediction, then picks tready.
  initial begin
    ecef_t e;
    logic signed [33:0] gx, gy, gz;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        gx = m_tdata[33:0];
        gy = m_tdata[67:34];
        gz = m_tdata[101:68];
        words_out++;
        if (ecef_due.size() == 0) begin
          flag_mismatch("words outstanding", 0, 1);
        end else begin
          e = ecef_due.pop_front();
          if (gx != e.x) flag_mismatch("ecef_x_mm", gx, e.x);
          if (gy != e.y) flag_mismatch("ecef_y_mm", gy, e.y);
          if (gz != e.z) flag_mismatch("ecef_z_mm", gz, e.z);
          if (e.on_axis && (gx != 0 || gy != 0)) flag_mismatch("pole x|y", gx | gy, 0);
        end
      end
      if (hold_request) begin
        // Long hold-off so that the pipeline fills and stalls its input.
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else begin
        m_tready <= rx_idle ? ($urandom_range(99) >= 32) : 1'b1;
      end
    end
  end

  geo_row_t directed [17] = '{
    '{32'd0, 31'd0, 28'd0, 1'b0},
    '{LON_MAX[31:0], 31'd0, 28'd0, 1'b0},
    '{-LON_MAX[31:0], 31'd0, 28'd0, 1'b0},                 // antimeridian
    '{LON_HALF, 31'd0, 28'd0, 1'b0},                       // quarter meridian
    '{-LON_HALF, 31'd0, 28'd0, 1'b0},
    '{LON_HALF + 32'd1, 31'd0, 28'd0, 1'b0},               // just folded
    '{-LON_HALF - 32'd1, 31'd0, 28'd0, 1'b0},
    '{32'd0, LAT_LIM, 28'd0, 1'b1},                        // north pole
    '{32'd12345678, -LAT_LIM, 28'd0, 1'b1},                // south pole
    '{32'd0, 31'd0, H_LIM, 1'b0},
    '{32'd0, 31'd0, -H_LIM, 1'b0},
    '{32'h7fff_ffff, 31'h3fff_ffff, 28'h7ff_ffff, 1'b1},   // saturated high
    '{32'h8000_0000, 31'h4000_0000, 28'h800_0000, 1'b1},   // saturated low
    '{32'hffff_ffff, 31'h7fff_ffff, 28'hfff_ffff, 1'b0},
    '{LON_HALF, LAT_LIM, H_LIM, 1'b1},
    '{-LON_MAX[31:0], -LAT_LIM, -H_LIM, 1'b1},
    '{32'd377487360, 31'd377487360, 28'd1000, 1'b0}        // 45 deg, 45 deg
  };

  function automatic logic [31:0] draw(longint lim);
    return 32'(longint'($urandom_range(2 * lim)) - lim);
  endfunction

  initial begin
    logic [31:0] lon;
    logic [30:0] lat;
    logic [27:0] hgt;
    int pick;
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mismatches = 0;
    words_in = 0;
    words_out = 0;
    rx_idle = 1'b1;
    tx_idle = 1'b1;
    hold_request = 1'b0;
    fill_atan_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_point(directed[i].lon, directed[i].lat, directed[i].hgt,
                                     directed[i].on_axis);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 600) begin
        s_tvalid <= 1'b0;
        while (ecef_due.size() != 0) @(posedge clk);
      end
      // A long stretch with both sides running flat out.
      rx_idle = !(n >= 700 && n < 1000);
      tx_idle = rx_idle;
      pick = $urandom_range(99);
      lon = draw(LON_MAX);
      lat = 31'(draw(LAT_MAX));
      hgt = 28'(draw(HGT_MAX));
      if (pick < 8) begin
        // Boundary values drawn from the special cases.
        case ($urandom_range(3))
          0: lon = $urandom_range(1) ? -LON_MAX[31:0] : LON_MAX[31:0];
          1: lon = $urandom_range(1) ? -LON_HALF : LON_HALF;
          2: lat = $urandom_range(1) ? -LAT_LIM : LAT_LIM;
          default: hgt = $urandom_range(1) ? -H_LIM : H_LIM;
        endcase
      end else if (pick < 20) begin
        lon = $urandom;
        lat = 31'($urandom);
        hgt = 28'($urandom);
      end
      send_point(lon, lat, hgt, 1'b0);
    end
    s_tvalid <= 1'b0;

    waited = 0;
    while (ecef_due.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d geodetic words (directed edges, saturation, poles, random) and checked %0d",
             words_in, words_out);
    $display("ECEF words, with idling on both sides, a long output hold-off and a full drain.");
    if (mismatches == 0 && ecef_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
